FILE: hdl/prdu_pkg.sv
package prdu_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int COEF_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;

    localparam int PROD_W = COEF_W + PIXEL_BITS + 1;
    localparam int H_W    = COEF_W + PIXEL_BITS + 2;
    localparam int HM_W   = H_W - 1;

    localparam int DIV_STEPS   = 2;
    localparam int QW          = HM_W + FRAC_BITS;
    localparam int HDIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int HN_W        = HDIV_STAGES * DIV_STEPS;
    localparam int QE_W        = (HN_W > 63) ? HN_W : 63;
    localparam int MQ_W        = 62;
    localparam logic [MQ_W-1:0] Q_SAT = '1;

    localparam int D_W   = 64;
    localparam int DM_W  = D_W - 1;
    localparam int POS_W = 6;
    localparam int M_W   = 31;
    localparam int SQ_W  = 2 * M_W;
    localparam int SUM_W = 64;
    localparam int LEN_W = 32;

    localparam int SQRT_ITERS  = SUM_W / 2;
    localparam int SQRT_STAGES = SQRT_ITERS / DIV_STEPS;

    localparam int UFRAC       = 30;
    localparam int UQ_W        = UFRAC + 1;
    localparam int UDIV_STAGES = UFRAC / DIV_STEPS;

    localparam int DIR_W = 32;
    localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1) << UFRAC;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_XY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_XY  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_XY  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_XY  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET01 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET23 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_CAM_XY   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z    = CFG_IDX_W'(7);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } t_in_word;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    degenerate;
    } t_out_word;

    typedef struct packed {
        logic [3:0][COEF_W-1:0] cx;
        logic [3:0][COEF_W-1:0] cy;
        logic [3:0][COEF_W-1:0] off;
        logic [2:0][COEF_W-1:0] pos;
    } t_cfg;

    typedef struct packed {
        logic [3:0][H_W-1:0] h;
    } t_h_word;

    typedef struct packed {
        logic [2:0][D_W-1:0] d;
        logic                deg;
    } t_d_word;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                deg;
    } t_sq_word;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                deg;
    } t_len_word;

endpackage

FILE: hdl/prdu_rows.sv
module prdu_rows (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  prdu_pkg::t_in_word i_word,
    input  prdu_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output prdu_pkg::t_h_word o_data
);
    import prdu_pkg::*;

    logic signed [PROD_W-1:0] r_prod_x [4];
    logic signed [PROD_W-1:0] r_prod_y [4];
    logic signed [PROD_W-1:0] n_prod_x [4];
    logic signed [PROD_W-1:0] n_prod_y [4];
    logic signed [H_W-1:0]    r_h [4];
    logic signed [H_W-1:0]    n_h [4];
    logic                     r_v1;
    logic                     r_v2;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_prod_x[r] = $signed(i_cfg.cx[r]) * $signed({1'b0, i_word.pixel_x});
            n_prod_y[r] = $signed(i_cfg.cy[r]) * $signed({1'b0, i_word.pixel_y});
            n_h[r] = H_W'(r_prod_x[r]) + H_W'(r_prod_y[r]) + H_W'($signed(i_cfg.off[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_h      <= n_h;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            o_data.h[r] = r_h[r];
        end
    end

    assign o_valid = r_v2;

endmodule

FILE: hdl/prdu_hdiv.sv
module prdu_hdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  prdu_pkg::t_h_word i_data,
    input  prdu_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output prdu_pkg::t_d_word o_data
);
    import prdu_pkg::*;

    logic [HM_W-1:0] r_rem [HDIV_STAGES+1][3];
    logic [HN_W-1:0] r_num [HDIV_STAGES+1][3];
    logic [HN_W-1:0] r_quo [HDIV_STAGES+1][3];
    logic [HM_W-1:0] r_b   [HDIV_STAGES+1];
    logic [2:0]      r_neg [HDIV_STAGES+1];
    logic            r_deg [HDIV_STAGES+1];

    logic [HM_W-1:0] n_rem [HDIV_STAGES][3];
    logic [HN_W-1:0] n_num [HDIV_STAGES][3];
    logic [HN_W-1:0] n_quo [HDIV_STAGES][3];

    logic [HN_W-1:0] n0_num [3];
    logic [2:0]      n0_neg;
    logic [HM_W-1:0] n0_b;

    logic signed [D_W-1:0] r_d [3];
    logic signed [D_W-1:0] n_d [3];
    logic                  r_out_deg;

    logic [HDIV_STAGES+1:0] r_valid;

    always_comb begin
        logic signed [H_W-1:0] hv;
        logic signed [H_W-1:0] habs;
        logic signed [H_W-1:0] wv;
        logic signed [H_W-1:0] wabs;
        wv   = $signed(i_data.h[3]);
        wabs = (wv < 0) ? -wv : wv;
        n0_b = wabs[HM_W-1:0];
        for (int l = 0; l < 3; l++) begin
            hv        = $signed(i_data.h[l]);
            habs      = (hv < 0) ? -hv : hv;
            n0_neg[l] = hv[H_W-1] ^ wv[H_W-1];
            n0_num[l] = HN_W'(habs[HM_W-1:0]) << FRAC_BITS;
        end
    end

    always_comb begin
        logic [HM_W-1:0] rem;
        logic [HN_W-1:0] num;
        logic [HN_W-1:0] quo;
        logic [HM_W:0]   r2;
        logic            qbit;
        for (int s = 0; s < HDIV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                rem = r_rem[s][l];
                num = r_num[s][l];
                quo = r_quo[s][l];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    r2  = {rem, num[HN_W-1]};
                    num = {num[HN_W-2:0], 1'b0};
                    if (r2 >= {1'b0, r_b[s]}) begin
                        rem  = HM_W'(r2 - {1'b0, r_b[s]});
                        qbit = 1'b1;
                    end else begin
                        rem  = r2[HM_W-1:0];
                        qbit = 1'b0;
                    end
                    quo = {quo[HN_W-2:0], qbit};
                end
                n_rem[s][l] = rem;
                n_num[s][l] = num;
                n_quo[s][l] = quo;
            end
        end
    end

    always_comb begin
        logic [QE_W-1:0]       qe;
        logic [MQ_W-1:0]       mq;
        logic signed [D_W-1:0] sv;
        for (int l = 0; l < 3; l++) begin
            qe = QE_W'(r_quo[HDIV_STAGES][l]);
            mq = ((qe >> MQ_W) != '0) ? Q_SAT : qe[MQ_W-1:0];
            sv = $signed(D_W'(mq));
            if (r_neg[HDIV_STAGES][l]) begin
                sv = -sv;
            end
            n_d[l] = sv - D_W'($signed(i_cfg.pos[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[HDIV_STAGES:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= '0;
                r_num[0][l] <= n0_num[l];
                r_quo[0][l] <= '0;
            end
            r_b[0]   <= n0_b;
            r_neg[0] <= n0_neg;
            r_deg[0] <= (i_data.h[3] == '0);
            for (int s = 0; s < HDIV_STAGES; s++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[s+1][l] <= n_rem[s][l];
                    r_num[s+1][l] <= n_num[s][l];
                    r_quo[s+1][l] <= n_quo[s][l];
                end
                r_b[s+1]   <= r_b[s];
                r_neg[s+1] <= r_neg[s];
                r_deg[s+1] <= r_deg[s];
            end
            r_d       <= n_d;
            r_out_deg <= r_deg[HDIV_STAGES];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_data.d[l] = r_d[l];
        end
        o_data.deg = r_out_deg;
    end

    assign o_valid = r_valid[HDIV_STAGES+1];

endmodule

FILE: hdl/prdu_norm.sv
module prdu_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  prdu_pkg::t_d_word  i_data,
    output logic               o_valid,
    output prdu_pkg::t_sq_word o_data
);
    import prdu_pkg::*;

    function automatic logic [POS_W-1:0] lead_one(input logic [DM_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int k = POS_W - 1; k >= 0; k--) begin
            if ((v >> (int'(p) + (1 << k))) != '0) begin
                p = p + POS_W'(1 << k);
            end
        end
        return p;
    endfunction

    logic [DM_W-1:0]  r1_mag [3];
    logic [DM_W-1:0]  n1_mag [3];
    logic [2:0]       r1_neg;
    logic [2:0]       n1_neg;
    logic             r1_deg;

    logic [DM_W-1:0]  r2_mag [3];
    logic [DM_W-1:0]  r2_or;
    logic [2:0]       r2_neg;
    logic             r2_deg;

    logic [DM_W-1:0]  r3_mag [3];
    logic [POS_W-1:0] r3_pos;
    logic [2:0]       r3_neg;
    logic             r3_deg;

    logic [M_W-1:0]   r4_m [3];
    logic [M_W-1:0]   n4_m [3];
    logic [2:0]       r4_neg;
    logic             r4_deg;

    logic [SQ_W-1:0]  r5_sq [3];
    logic [M_W-1:0]   r5_m [3];
    logic [2:0]       r5_neg;
    logic             r5_deg;

    logic [SUM_W-1:0] r6_sum;
    logic [M_W-1:0]   r6_m [3];
    logic [2:0]       r6_neg;
    logic             r6_deg;

    logic [5:0]       r_valid;

    always_comb begin
        logic signed [D_W-1:0] dv;
        logic signed [D_W-1:0] dabs;
        for (int l = 0; l < 3; l++) begin
            dv        = $signed(i_data.d[l]);
            dabs      = (dv < 0) ? -dv : dv;
            n1_mag[l] = dabs[DM_W-1:0];
            n1_neg[l] = dv[D_W-1];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r3_pos > POS_W'(M_W - 1)) begin
                n4_m[l] = M_W'(r3_mag[l] >> (r3_pos - POS_W'(M_W - 1)));
            end else begin
                n4_m[l] = M_W'(r3_mag[l] << (POS_W'(M_W - 1) - r3_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag <= n1_mag;
            r1_neg <= n1_neg;
            r1_deg <= i_data.deg;

            r2_mag <= r1_mag;
            r2_or  <= r1_mag[0] | r1_mag[1] | r1_mag[2];
            r2_neg <= r1_neg;
            r2_deg <= r1_deg || ((r1_mag[0] | r1_mag[1] | r1_mag[2]) == '0);

            r3_mag <= r2_mag;
            r3_pos <= lead_one(r2_or);
            r3_neg <= r2_neg;
            r3_deg <= r2_deg;

            r4_m   <= n4_m;
            r4_neg <= r3_neg;
            r4_deg <= r3_deg;

            for (int l = 0; l < 3; l++) begin
                r5_sq[l] <= SQ_W'(r4_m[l]) * SQ_W'(r4_m[l]);
            end
            r5_m   <= r4_m;
            r5_neg <= r4_neg;
            r5_deg <= r4_deg;

            r6_sum <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1]) + SUM_W'(r5_sq[2]);
            r6_m   <= r5_m;
            r6_neg <= r5_neg;
            r6_deg <= r5_deg;
        end
    end

    always_comb begin
        o_data.sum = r6_sum;
        for (int l = 0; l < 3; l++) begin
            o_data.m[l] = r6_m[l];
        end
        o_data.neg = r6_neg;
        o_data.deg = r6_deg;
    end

    assign o_valid = r_valid[5];

endmodule

FILE: hdl/prdu_isqrt.sv
module prdu_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  prdu_pkg::t_sq_word  i_data,
    output logic                o_valid,
    output prdu_pkg::t_len_word o_data
);
    import prdu_pkg::*;

    logic [SUM_W-1:0]    r_v   [SQRT_STAGES+1];
    logic [SUM_W-1:0]    r_res [SQRT_STAGES+1];
    logic [2:0][M_W-1:0] r_m   [SQRT_STAGES+1];
    logic [2:0]          r_neg [SQRT_STAGES+1];
    logic                r_deg [SQRT_STAGES+1];
    logic [SUM_W-1:0]    n_v   [SQRT_STAGES];
    logic [SUM_W-1:0]    n_res [SQRT_STAGES];
    logic [SQRT_STAGES:0] r_valid;

    always_comb begin
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] res;
        logic [SUM_W-1:0] sbit;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            v   = r_v[s];
            res = r_res[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                sbit = SUM_W'(1) << (SUM_W - 2 - 2 * (s * DIV_STEPS + k));
                if (v >= res + sbit) begin
                    v   = v - (res + sbit);
                    res = (res >> 1) + sbit;
                end else begin
                    res = res >> 1;
                end
            end
            n_v[s]   = v;
            n_res[s] = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[SQRT_STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]   <= i_data.sum;
            r_res[0] <= '0;
            r_m[0]   <= i_data.m;
            r_neg[0] <= i_data.neg;
            r_deg[0] <= i_data.deg;
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_v[s+1]   <= n_v[s];
                r_res[s+1] <= n_res[s];
                r_m[s+1]   <= r_m[s];
                r_neg[s+1] <= r_neg[s];
                r_deg[s+1] <= r_deg[s];
            end
        end
    end

    always_comb begin
        o_data.len = r_res[SQRT_STAGES][LEN_W-1:0];
        o_data.m   = r_m[SQRT_STAGES];
        o_data.neg = r_neg[SQRT_STAGES];
        o_data.deg = r_deg[SQRT_STAGES];
    end

    assign o_valid = r_valid[SQRT_STAGES];

endmodule

FILE: hdl/prdu_udiv.sv
module prdu_udiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  prdu_pkg::t_len_word i_data,
    output logic                o_valid,
    output prdu_pkg::t_out_word o_data
);
    import prdu_pkg::*;

    logic [LEN_W-1:0] r_rem [UDIV_STAGES+1][3];
    logic [UQ_W-1:0]  r_quo [UDIV_STAGES+1][3];
    logic [LEN_W-1:0] r_len [UDIV_STAGES+1];
    logic [2:0]       r_neg [UDIV_STAGES+1];
    logic             r_deg [UDIV_STAGES+1];
    logic [LEN_W-1:0] n_rem [UDIV_STAGES][3];
    logic [UQ_W-1:0]  n_quo [UDIV_STAGES][3];
    logic [LEN_W-1:0] n0_rem [3];
    logic [UQ_W-1:0]  n0_quo [3];

    logic signed [DIR_W-1:0] r_dir [3];
    logic signed [DIR_W-1:0] n_dir [3];
    logic                    r_out_deg;

    logic [UDIV_STAGES+1:0] r_valid;

    always_comb begin
        logic [LEN_W-1:0] mx;
        logic             ip;
        for (int l = 0; l < 3; l++) begin
            mx = LEN_W'(i_data.m[l]);
            ip = (mx >= i_data.len);
            n0_rem[l] = ip ? (mx - i_data.len) : mx;
            n0_quo[l] = UQ_W'(ip);
        end
    end

    always_comb begin
        logic [LEN_W-1:0] rem;
        logic [UQ_W-1:0]  quo;
        logic [LEN_W:0]   r2;
        logic             qbit;
        for (int s = 0; s < UDIV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                rem = r_rem[s][l];
                quo = r_quo[s][l];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    r2 = {rem, 1'b0};
                    if (r2 >= {1'b0, r_len[s]}) begin
                        rem  = LEN_W'(r2 - {1'b0, r_len[s]});
                        qbit = 1'b1;
                    end else begin
                        rem  = r2[LEN_W-1:0];
                        qbit = 1'b0;
                    end
                    quo = {quo[UQ_W-2:0], qbit};
                end
                n_rem[s][l] = rem;
                n_quo[s][l] = quo;
            end
        end
    end

    always_comb begin
        logic signed [DIR_W-1:0] qv;
        for (int l = 0; l < 3; l++) begin
            qv = $signed(DIR_W'(r_quo[UDIV_STAGES][l]));
            if (r_deg[UDIV_STAGES]) begin
                n_dir[l] = '0;
            end else if (r_neg[UDIV_STAGES][l]) begin
                n_dir[l] = -qv;
            end else begin
                n_dir[l] = qv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[UDIV_STAGES:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= n0_rem[l];
                r_quo[0][l] <= n0_quo[l];
            end
            r_len[0] <= i_data.len;
            r_neg[0] <= i_data.neg;
            r_deg[0] <= i_data.deg;
            for (int s = 0; s < UDIV_STAGES; s++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[s+1][l] <= n_rem[s][l];
                    r_quo[s+1][l] <= n_quo[s][l];
                end
                r_len[s+1] <= r_len[s];
                r_neg[s+1] <= r_neg[s];
                r_deg[s+1] <= r_deg[s];
            end
            r_dir     <= n_dir;
            r_out_deg <= r_deg[UDIV_STAGES];
        end
    end

    always_comb begin
        o_data.dir_x      = r_dir[0];
        o_data.dir_y      = r_dir[1];
        o_data.dir_z      = r_dir[2];
        o_data.degenerate = r_out_deg;
    end

    assign o_valid = r_valid[UDIV_STAGES+1];

endmodule

FILE: hdl/pixel_ray_direction_unit.sv
// Pixel ray direction unit. Each input word carries one pixel coordinate and produces one
// output word with the unit ray direction in signed Q1.30 and a degenerate flag. The block
// is a fully pipelined datapath: it accepts a new word every cycle unless the output
// stalls. The pipeline depth is set by the bit-serial stages of the projective divider
// (two quotient bits per stage), the square root (two iterations per stage) and the final
// normalizing divider. A stall at the output freezes the whole pipeline and is passed back
// to the input in the same cycle. The user must write the matrix and camera registers
// via the configuration port while no word is in flight; the block does not enforce it.
module pixel_ray_direction_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  prdu_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output prdu_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [prdu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prdu_pkg::CFG_W-1:0]         i_cfg_data
);
    import prdu_pkg::*;

    logic [CFG_W-1:0]  r_row_xy [4];
    logic [CFG_W-1:0]  r_off01;
    logic [CFG_W-1:0]  r_off23;
    logic [CFG_W-1:0]  r_cam_xy;
    logic [COEF_W-1:0] r_cam_z;

    t_cfg      cfg;
    logic      en;
    logic      rows_valid;
    t_h_word   rows_data;
    logic      hdiv_valid;
    t_d_word   hdiv_data;
    logic      norm_valid;
    t_sq_word  norm_data;
    logic      sqrt_valid;
    t_len_word sqrt_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                r_row_xy[r] <= '0;
            end
            r_off01  <= '0;
            r_off23  <= CFG_W'(1) << COEF_W;
            r_cam_xy <= '0;
            r_cam_z  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW0_XY:  r_row_xy[0] <= i_cfg_data;
                REG_ROW1_XY:  r_row_xy[1] <= i_cfg_data;
                REG_ROW2_XY:  r_row_xy[2] <= i_cfg_data;
                REG_ROW3_XY:  r_row_xy[3] <= i_cfg_data;
                REG_OFFSET01: r_off01     <= i_cfg_data;
                REG_OFFSET23: r_off23     <= i_cfg_data;
                REG_CAM_XY:   r_cam_xy    <= i_cfg_data;
                REG_CAM_Z:    r_cam_z     <= i_cfg_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            cfg.cx[r] = r_row_xy[r][COEF_W-1:0];
            cfg.cy[r] = r_row_xy[r][CFG_W-1:COEF_W];
        end
        cfg.off[0] = r_off01[COEF_W-1:0];
        cfg.off[1] = r_off01[CFG_W-1:COEF_W];
        cfg.off[2] = r_off23[COEF_W-1:0];
        cfg.off[3] = r_off23[CFG_W-1:COEF_W];
        cfg.pos[0] = r_cam_xy[COEF_W-1:0];
        cfg.pos[1] = r_cam_xy[CFG_W-1:COEF_W];
        cfg.pos[2] = r_cam_z;
    end

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    prdu_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_valid (rows_valid),
        .o_data  (rows_data)
    );

    prdu_hdiv u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rows_valid),
        .i_data  (rows_data),
        .i_cfg   (cfg),
        .o_valid (hdiv_valid),
        .o_data  (hdiv_data)
    );

    prdu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hdiv_valid),
        .i_data  (hdiv_data),
        .o_valid (norm_valid),
        .o_data  (norm_data)
    );

    prdu_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_valid),
        .i_data  (norm_data),
        .o_valid (sqrt_valid),
        .o_data  (sqrt_data)
    );

    prdu_udiv u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_valid),
        .i_data  (sqrt_data),
        .o_valid (o_out_valid),
        .o_data  (o_out_word)
    );

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.degenerate |->
            (o_out_word.dir_x <= DIR_ONE) && (o_out_word.dir_x >= -DIR_ONE) &&
            (o_out_word.dir_y <= DIR_ONE) && (o_out_word.dir_y >= -DIR_ONE) &&
            (o_out_word.dir_z <= DIR_ONE) && (o_out_word.dir_z >= -DIR_ONE))
        else $error("Direction component exceeds unit range.");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.degenerate |->
            (o_out_word.dir_x == '0) && (o_out_word.dir_y == '0) && (o_out_word.dir_z == '0))
        else $error("Degenerate word carries a nonzero direction.");

    a_nonzero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.degenerate |->
            (o_out_word.dir_x != '0) || (o_out_word.dir_y != '0) || (o_out_word.dir_z != '0))
        else $error("Valid direction has zero length.");

endmodule
